// ----- sv/acld_pkg.sv -----
package acld_pkg;

  localparam int unsigned MaxLineBytes = 64;
  localparam int unsigned IdLimit      = 3;
  localparam int unsigned NameBytes    = 6;
  localparam int unsigned NameW        = 8 * NameBytes;
  localparam int unsigned LineCntW     = $clog2(MaxLineBytes + 1);
  localparam int unsigned FieldCntW    = 3;
  localparam int unsigned ArgW         = 32;

  localparam logic [FieldCntW-1:0] FieldLast = FieldCntW'(4);

  localparam logic [7:0] AsciiTab    = 8'h09;
  localparam logic [7:0] AsciiLf     = 8'h0a;
  localparam logic [7:0] AsciiCr     = 8'h0d;
  localparam logic [7:0] AsciiSpace  = 8'h20;
  localparam logic [7:0] AsciiPlus   = 8'h2b;
  localparam logic [7:0] AsciiComma  = 8'h2c;
  localparam logic [7:0] AsciiMinus  = 8'h2d;
  localparam logic [7:0] AsciiZero   = 8'h30;
  localparam logic [7:0] AsciiNine   = 8'h39;
  localparam logic [7:0] AsciiUpperA = 8'h41;
  localparam logic [7:0] AsciiUpperZ = 8'h5a;
  localparam logic [7:0] CaseOffset  = 8'h20;

  // names are held first byte in the top bits
  localparam logic [NameW-1:0] NameLedset = "ledset";
  localparam logic [NameW-1:0] NameLedclr = "ledclr";
  localparam logic [NameW-1:0] NameLedinv = "ledinv";
  localparam logic [NameW-1:0] NameLedget = "ledget";
  localparam logic [NameW-1:0] NamePswget = "pswget";
  localparam logic [NameW-1:0] NameAdcget = "adcget";
  localparam logic [NameW-1:0] NameLedfls = "ledfls";
  localparam logic [NameW-1:0] NameLedpwm = "ledpwm";
  localparam logic [NameW-1:0] NameSndset = "sndset";
  localparam logic [23:0]      PfxLed     = "led";
  localparam logic [23:0]      PfxPsw     = "psw";
  localparam logic [23:0]      PfxAdc     = "adc";

  localparam logic signed [ArgW-1:0] ArgAbsent  = -32'sd1;
  localparam logic signed [ArgW-1:0] ArgZero    = 32'sd0;
  localparam logic signed [ArgW-1:0] ArgMax     = 32'sh7fff_ffff;
  localparam logic signed [ArgW-1:0] IdMax      = ArgW'(IdLimit);
  localparam logic signed [ArgW-1:0] FlashMin   = 32'sd1;
  localparam logic signed [ArgW-1:0] SndAMin    = 32'sd1;
  localparam logic signed [ArgW-1:0] SndAMax    = 32'sd5000;
  localparam logic signed [ArgW-1:0] SndBMin    = 32'sd10;
  localparam logic signed [ArgW-1:0] SndBMax    = 32'sd20000;
  localparam logic signed [ArgW-1:0] SndCMin    = 32'sd0;
  localparam logic signed [ArgW-1:0] SndCMax    = 32'sd100;

  typedef enum logic [3:0] {
    CmdSet     = 4'd0,
    CmdClear   = 4'd1,
    CmdInvert  = 4'd2,
    CmdLedGet  = 4'd3,
    CmdPswGet  = 4'd4,
    CmdAdcGet  = 4'd5,
    CmdFlash   = 4'd6,
    CmdPwm     = 4'd7,
    CmdSound   = 4'd8,
    CmdUnknown = 4'd9
  } cmd_code_e;

  typedef enum logic {
    ReplyStatus = 1'b0,
    ReplyValue  = 1'b1
  } reply_kind_e;

  typedef struct packed {
    logic clear;
    logic feed;
  } fld_ctrl_t;

  typedef struct packed {
    logic [NameW-1:0]     name;
    logic [1:0]           id_bits;
    logic signed [ArgW-1:0] arg_a;
    logic signed [ArgW-1:0] arg_b;
    logic signed [ArgW-1:0] arg_c;
    logic [FieldCntW-1:0] field_cnt;
    logic                 bad;
    logic                 cr_seen;
  } line_sum_t;

  typedef struct packed {
    cmd_code_e            code;
    reply_kind_e          kind;
    logic                 ok;
    logic [1:0]           target_id;
    logic signed [ArgW-1:0] arg_a;
    logic signed [ArgW-1:0] arg_b;
    logic signed [ArgW-1:0] arg_c;
  } acld_result_t;

endpackage

// ----- sv/acld_in_if.sv -----
interface acld_in_if import acld_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// ----- sv/acld_out_if.sv -----
interface acld_out_if import acld_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [3:0]             cmd_code;
  logic                   reply_kind;
  logic                   ok;
  logic [1:0]             target_id;
  logic signed [ArgW-1:0] arg_a;
  logic signed [ArgW-1:0] arg_b;
  logic signed [ArgW-1:0] arg_c;

  modport source (
    output valid, output cmd_code, output reply_kind, output ok, output target_id,
    output arg_a, output arg_b, output arg_c, input ready
  );
  modport sink (
    input valid, input cmd_code, input reply_kind, input ok, input target_id,
    input arg_a, input arg_b, input arg_c, output ready
  );
endinterface

// ----- sv/acld_field.sv -----
module acld_field import acld_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [7:0]             byte_i,
  input  fld_ctrl_t              ctl_i,
  output logic signed [ArgW-1:0] value_o,
  output logic                   digits_ok_o
);

  logic [ArgW-1:0]   accum_q, accum_d;
  logic              neg_q, neg_d;
  logic              digits_q, digits_d;
  logic              started_q, started_d;
  logic [ArgW+3:0]   mul_ten;
  logic              is_digit;
  logic [ArgW-1:0]   digit_val;

  always_comb begin
    is_digit  = (byte_i >= AsciiZero) && (byte_i <= AsciiNine);
    digit_val = ArgW'(byte_i - AsciiZero);
    mul_ten   = ({4'b0000, accum_q} << 3) + ({4'b0000, accum_q} << 1)
                + {4'b0000, digit_val};

    accum_d   = accum_q;
    neg_d     = neg_q;
    digits_d  = digits_q;
    started_d = started_q;

    if (ctl_i.clear) begin
      accum_d   = '0;
      neg_d     = 1'b0;
      digits_d  = 1'b1;
      started_d = 1'b0;
    end else if (ctl_i.feed) begin
      started_d = 1'b1;
      if (!started_q && ((byte_i == AsciiPlus) || (byte_i == AsciiMinus))) begin
        neg_d = (byte_i == AsciiMinus);
      end else if (is_digit) begin
        // magnitude saturates at 2^31
        if (mul_ten > {4'b0000, 1'b1, {(ArgW-1){1'b0}}}) begin
          accum_d = {1'b1, {(ArgW-1){1'b0}}};
        end else begin
          accum_d = mul_ten[ArgW-1:0];
        end
      end else begin
        digits_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q   <= '0;
      neg_q     <= 1'b0;
      digits_q  <= 1'b1;
      started_q <= 1'b0;
    end else begin
      accum_q   <= accum_d;
      neg_q     <= neg_d;
      digits_q  <= digits_d;
      started_q <= started_d;
    end
  end

  always_comb begin
    if (neg_q) begin
      value_o = -$signed(accum_q);
    end else if (accum_q[ArgW-1]) begin
      value_o = ArgMax;
    end else begin
      value_o = $signed(accum_q);
    end
  end

  assign digits_ok_o = digits_q;

endmodule

// ----- sv/acld_check.sv -----
module acld_check import acld_pkg::*; (
  input  line_sum_t    sum_i,
  output logic         emit_o,
  output acld_result_t res_o
);

  cmd_code_e   code;
  reply_kind_e kind;
  logic        ok_base;
  logic        ok;
  logic [23:0] pfx;

  always_comb begin
    pfx    = sum_i.name[NameW-1 -: 24];
    emit_o = 1'b1;
    code   = CmdUnknown;
    kind   = ReplyValue;

    if (sum_i.name == NameLedfls) begin
      code = CmdFlash;
      kind = ReplyStatus;
    end else if (sum_i.name == NameLedpwm) begin
      code = CmdPwm;
      kind = ReplyStatus;
    end else if (sum_i.name == NameSndset) begin
      code = CmdSound;
      kind = ReplyStatus;
    end else if ((pfx == PfxLed) || (pfx == PfxPsw) || (pfx == PfxAdc)) begin
      if (sum_i.name == NameLedset) begin
        code = CmdSet;
      end else if (sum_i.name == NameLedclr) begin
        code = CmdClear;
      end else if (sum_i.name == NameLedinv) begin
        code = CmdInvert;
      end else if (sum_i.name == NameLedget) begin
        code = CmdLedGet;
      end else if (sum_i.name == NamePswget) begin
        code = CmdPswGet;
      end else if (sum_i.name == NameAdcget) begin
        code = CmdAdcGet;
      end
    end else begin
      emit_o = 1'b0;
    end

    ok_base = !sum_i.bad && sum_i.cr_seen && (code != CmdUnknown);
    case (code)
      CmdFlash: ok = ok_base && (sum_i.arg_a >= FlashMin);
      CmdPwm: begin
        ok = ok_base && (sum_i.field_cnt == FieldLast) && (sum_i.arg_a >= ArgZero)
             && (sum_i.arg_b >= ArgZero) && (sum_i.arg_c >= ArgZero);
      end
      CmdSound: begin
        ok = ok_base && (sum_i.arg_a >= SndAMin) && (sum_i.arg_a <= SndAMax)
             && (sum_i.arg_b >= SndBMin) && (sum_i.arg_b <= SndBMax)
             && (sum_i.arg_c >= SndCMin) && (sum_i.arg_c <= SndCMax);
      end
      default: ok = ok_base;
    endcase

    res_o.code      = code;
    res_o.kind      = kind;
    res_o.ok        = ok;
    res_o.target_id = ok ? sum_i.id_bits : 2'b00;
    res_o.arg_a     = ok ? sum_i.arg_a : ArgAbsent;
    res_o.arg_b     = ok ? sum_i.arg_b : ArgAbsent;
    res_o.arg_c     = ok ? sum_i.arg_c : ArgAbsent;
  end

endmodule

// ----- sv/ascii_command_line_decoder.sv -----
// Decodes one text command line per LF, one received byte per transaction.
// Spaces and tabs are dropped and upper case is folded; the name prefix
// selects the command, and the comma separated id and up to three signed
// decimal arguments follow. A line whose name starts with led, psw or adc,
// or is sndset, gives one result transaction on its LF; any other line gives
// none. A byte can be taken every cycle while no result waits to be taken:
// each byte passes an input register and then the line-state update that
// loads the result register that offers the result. While a result waits
// to be taken one more byte is still accepted into the input register.
module ascii_command_line_decoder import acld_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  acld_in_if.sink     in_i,
  acld_out_if.source  out_o
);

  logic [7:0]             byte_q;
  logic                   byte_vld_q;
  logic                   process;
  logic                   in_take;

  logic [7:0]             fb;
  logic                   drop;
  logic                   take;
  logic                   is_lf;
  logic                   is_cr;
  logic                   is_comma;

  logic [NameW-1:0]       name_q, name_d;
  logic [LineCntW-1:0]    cnt_q, cnt_d;
  logic [FieldCntW-1:0]   fn_q, fn_d;
  logic [FieldCntW-1:0]   fn_m1;
  logic signed [ArgW-1:0] held_q [4];
  logic signed [ArgW-1:0] held_d [4];
  logic signed [ArgW-1:0] held_cl [4];
  logic                   bad_q, bad_d;
  logic                   cr_q, cr_d;

  fld_ctrl_t              fctl;
  logic signed [ArgW-1:0] fld_value;
  logic                   fld_digits_ok;
  logic                   id_bad;
  logic                   bad_close;

  line_sum_t              sum;
  logic                   emit;
  acld_result_t           res, res_q;
  logic                   out_vld_q;

  // input register
  assign process    = byte_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !byte_vld_q || process;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (in_take) begin
      byte_vld_q <= 1'b1;
    end else if (process) begin
      byte_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= in_i.in_byte;
    end
  end

  always_comb begin
    fb = byte_q;
    if (byte_q inside {[AsciiUpperA:AsciiUpperZ]}) begin
      fb = byte_q + CaseOffset;
    end
    drop     = (byte_q == AsciiSpace) || (byte_q == AsciiTab);
    take     = process && !drop;
    is_lf    = (fb == AsciiLf);
    is_cr    = (fb == AsciiCr);
    is_comma = (fb == AsciiComma);
  end

  acld_field u_field (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (fb),
    .ctl_i       (fctl),
    .value_o     (fld_value),
    .digits_ok_o (fld_digits_ok)
  );

  // closing the current field
  always_comb begin
    fn_m1 = fn_q - FieldCntW'(1);
    for (int i = 0; i < 4; i++) begin
      held_cl[i] = ((fn_q != '0) && fld_digits_ok && (fn_m1[1:0] == 2'(i)))
                   ? fld_value : held_q[i];
    end
    id_bad    = (fn_q == FieldCntW'(1)) && ((fld_value < ArgZero) || (fld_value > IdMax));
    bad_close = (fn_q != '0) && (!fld_digits_ok || id_bad);
  end

  always_comb begin
    name_d = name_q;
    cnt_d  = cnt_q;
    fn_d   = fn_q;
    held_d = held_q;
    bad_d  = bad_q;
    cr_d   = cr_q;
    fctl   = '0;

    if (take && is_lf) begin
      name_d     = '0;
      cnt_d      = '0;
      fn_d       = '0;
      held_d     = '{default: ArgAbsent};
      bad_d      = 1'b0;
      cr_d       = 1'b0;
      fctl.clear = 1'b1;
    end else if (take) begin
      if (cnt_q < LineCntW'(NameBytes)) begin
        name_d[8 * (3'(NameBytes - 1) - cnt_q[2:0]) +: 8] = fb;
      end
      if (cnt_q != LineCntW'(MaxLineBytes)) begin
        cnt_d = cnt_q + LineCntW'(1);
      end
      if (cnt_q >= LineCntW'(MaxLineBytes - 1)) begin
        bad_d = 1'b1;
      end
      if (is_cr) begin
        cr_d = 1'b1;
      end else begin
        if (cr_q) begin
          bad_d = 1'b1;
          cr_d  = 1'b0;
        end
        if (is_comma) begin
          held_d = held_cl;
          if (bad_close) begin
            bad_d = 1'b1;
          end
          if (fn_q < FieldLast) begin
            fn_d = fn_q + FieldCntW'(1);
          end else begin
            bad_d = 1'b1;
          end
          fctl.clear = 1'b1;
        end else if (fn_q != '0) begin
          fctl.feed = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_q <= '0;
      cnt_q  <= '0;
      fn_q   <= '0;
      held_q <= '{default: ArgAbsent};
      bad_q  <= 1'b0;
      cr_q   <= 1'b0;
    end else begin
      name_q <= name_d;
      cnt_q  <= cnt_d;
      fn_q   <= fn_d;
      held_q <= held_d;
      bad_q  <= bad_d;
      cr_q   <= cr_d;
    end
  end

  // end of line summary
  always_comb begin
    sum.name      = name_q;
    sum.id_bits   = held_cl[0][1:0];
    sum.arg_a     = held_cl[1];
    sum.arg_b     = held_cl[2];
    sum.arg_c     = held_cl[3];
    sum.field_cnt = fn_q;
    sum.bad       = bad_q || (fn_q == '0) || bad_close;
    sum.cr_seen   = cr_q;
  end

  acld_check u_check (
    .sum_i  (sum),
    .emit_o (emit),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (take && is_lf && emit) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && is_lf && emit) begin
      res_q <= res;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.cmd_code   = res_q.code;
  assign out_o.reply_kind = res_q.kind;
  assign out_o.ok         = res_q.ok;
  assign out_o.target_id  = res_q.target_id;
  assign out_o.arg_a      = res_q.arg_a;
  assign out_o.arg_b      = res_q.arg_b;
  assign out_o.arg_c      = res_q.arg_c;

`ifndef SYNTHESIS
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_q.ok |-> (res_q.target_id == 2'b00) && (res_q.arg_a == ArgAbsent)
      && (res_q.arg_b == ArgAbsent) && (res_q.arg_c == ArgAbsent))
    else $error("error result carries decoded fields");

  a_ok_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.ok |-> (res_q.code != CmdUnknown))
    else $error("unknown command reported ok");

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LineCntW'(MaxLineBytes))
    else $error("line byte count beyond cap");

  a_fn_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fn_q <= FieldLast)
    else $error("field number beyond last field");

  a_lf_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && is_lf |=> (cnt_q == '0) && (fn_q == '0) && !bad_q && !cr_q)
    else $error("line state not cleared after line feed");
`endif

endmodule

// ----- bench/tb_ascii_command_line_decoder.sv -----
module tb_ascii_command_line_decoder;
  import acld_pkg::*;

  localparam int unsigned CycleLimit = 250000;
  localparam int unsigned HoldCycles = 300;

  typedef logic [7:0] byte_q_t [$];

  class cmd_line_tracker;
    logic [7:0]    name_buf [NameBytes];
    int unsigned   kept;
    int unsigned   field_no;
    longint        mag;
    bit            neg;
    bit            digits_only;
    bit            started;
    bit            bad;
    bit            cr_last;
    longint        held [4];
    acld_result_t  expected_cmds [$];
    int unsigned   cmds_expected;
    int unsigned   fails;

    function new();
      cmds_expected = 0;
      fails         = 0;
      restart();
    endfunction

    function void restart_field();
      mag         = 0;
      neg         = 0;
      digits_only = 1;
      started     = 0;
    endfunction

    function void restart();
      foreach (name_buf[k]) name_buf[k] = 8'h00;
      foreach (held[k]) held[k] = -1;
      kept     = 0;
      field_no = 0;
      bad      = 0;
      cr_last  = 0;
      restart_field();
    endfunction

    function bit name_is(string word);
      for (int k = 0; k < word.len(); k++) begin
        if (k >= NameBytes || k >= kept) return 0;
        if (name_buf[k] != word[k]) return 0;
      end
      return 1;
    endfunction

    function void close_field();
      longint v;
      if (field_no < 1 || field_no > 4) return;
      if (!digits_only) begin
        bad = 1;
        return;
      end
      v = neg ? -mag : ((mag > 64'sh7fff_ffff) ? 64'sh7fff_ffff : mag);
      held[field_no-1] = v;
      if (field_no == 1 && (v < 0 || v > longint'(IdLimit))) bad = 1;
    endfunction

    function void field_byte(logic [7:0] b);
      if (!started && (b == AsciiPlus || b == AsciiMinus)) begin
        neg = (b == AsciiMinus);
      end else if (b >= AsciiZero && b <= AsciiNine) begin
        mag = mag * 10 + longint'(b - AsciiZero);
        if (mag > 64'sh8000_0000) mag = 64'sh8000_0000;
      end else begin
        digits_only = 0;
      end
      started = 1;
    endfunction

    function void end_of_line();
      acld_result_t r;
      cmd_code_e    code;
      bit           emit;
      bit           ok;
      longint       a;
      longint       bv;
      longint       c;
      code = CmdUnknown;
      emit = 1;
      if (field_no == 0) bad = 1;
      else close_field();
      a  = held[1];
      bv = held[2];
      c  = held[3];
      if (name_is("ledfls")) code = CmdFlash;
      else if (name_is("ledpwm")) code = CmdPwm;
      else if (name_is("sndset")) code = CmdSound;
      else if (name_is("led") || name_is("psw") || name_is("adc")) begin
        if (name_is("ledset")) code = CmdSet;
        else if (name_is("ledclr")) code = CmdClear;
        else if (name_is("ledinv")) code = CmdInvert;
        else if (name_is("ledget")) code = CmdLedGet;
        else if (name_is("pswget")) code = CmdPswGet;
        else if (name_is("adcget")) code = CmdAdcGet;
      end else begin
        emit = 0;
      end
      ok = !bad && cr_last && code != CmdUnknown;
      case (code)
        CmdFlash: ok = ok && a >= FlashMin;
        CmdPwm:   ok = ok && field_no == 4 && a >= 0 && bv >= 0 && c >= 0;
        CmdSound: ok = ok && a >= SndAMin && a <= SndAMax && bv >= SndBMin && bv <= SndBMax
                          && c >= SndCMin && c <= SndCMax;
        default: ;
      endcase
      if (emit) begin
        r.code      = code;
        r.kind      = (code == CmdFlash || code == CmdPwm || code == CmdSound)
                      ? ReplyStatus : ReplyValue;
        r.ok        = ok;
        r.target_id = ok ? 2'(held[0]) : 2'd0;
        r.arg_a     = ok ? 32'(a) : ArgAbsent;
        r.arg_b     = ok ? 32'(bv) : ArgAbsent;
        r.arg_c     = ok ? 32'(c) : ArgAbsent;
        expected_cmds.push_back(r);
        cmds_expected++;
      end
      restart();
    endfunction

    function void take_byte(logic [7:0] raw);
      logic [7:0] b;
      b = raw;
      if (b == AsciiSpace || b == AsciiTab) return;
      if (b >= AsciiUpperA && b <= AsciiUpperZ) b = b + CaseOffset;
      if (b == AsciiLf) begin
        end_of_line();
        return;
      end
      if (kept < NameBytes) name_buf[kept] = b;
      kept++;
      if (kept >= MaxLineBytes) bad = 1;
      if (b == AsciiCr) begin
        cr_last = 1;
        return;
      end
      if (cr_last) begin
        bad     = 1;
        cr_last = 0;
      end
      if (b == AsciiComma) begin
        close_field();
        if (field_no < 4) field_no++;
        else bad = 1;
        restart_field();
      end else if (field_no >= 1) begin
        field_byte(b);
      end
    endfunction

    task report(string what);
      if (fails < 40) $display("mismatch: %s", what);
      fails++;
    endtask

    task check_reply(acld_result_t got);
      acld_result_t want;
      if (expected_cmds.size() == 0) begin
        report($sformatf("result with no line pending, code %0d", got.code));
        return;
      end
      want = expected_cmds.pop_front();
      if (got.code !== want.code)
        report($sformatf("cmd_code %0d, want %0d", got.code, want.code));
      if (got.kind !== want.kind)
        report($sformatf("reply_kind %0d, want %0d", got.kind, want.kind));
      if (got.ok !== want.ok)
        report($sformatf("ok %0d, want %0d (code %0d)", got.ok, want.ok, want.code));
      if (got.target_id !== want.target_id)
        report($sformatf("target_id %0d, want %0d", got.target_id, want.target_id));
      if (got.arg_a !== want.arg_a)
        report($sformatf("arg_a %0d, want %0d", got.arg_a, want.arg_a));
      if (got.arg_b !== want.arg_b)
        report($sformatf("arg_b %0d, want %0d", got.arg_b, want.arg_b));
      if (got.arg_c !== want.arg_c)
        report($sformatf("arg_c %0d, want %0d", got.arg_c, want.arg_c));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  acld_in_if  in_if ();
  acld_out_if out_if ();

  ascii_command_line_decoder i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  cmd_line_tracker line_model = new();

  bit          idle_on = 1;
  bit          hold_out = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;

  string directed_lines [] = '{
    "ledset,0\r\n",
    "LEDCLR , 3 ,\t5\r\n",
    "LeDiNv,1,,\r\n",
    "ledget,2,+7,-0,2147483647\r\n",
    "pswget,3,99999999999,-99999999999,-2147483648\r\n",
    "adcget,0,+,-\r\n",
    "ledfls,1,1\r\n",
    "ledfls,2,0\r\n",
    "ledfls,3\r\n",
    "ledpwm,2,0,0,0\r\n",
    "ledpwm,2,1,2\r\n",
    "sndset,0,5000,20000,100\r\n",
    "SNDSET,1,1,10,0\r\n",
    "sndset,0,5001,9,101\r\n",
    "ledset,0\n",
    "ledset,0\rx\r\n",
    "ledget\r\n",
    "ledset,0,1,2,3,4\r\n",
    "ledset,0,1a\r\n",
    "ledset,0,+-5\r\n",
    "ledset,4\r\n",
    "ledset,-1\r\n",
    "ledxyz,0\r\n",
    "led,0\r\n",
    "le\r\n",
    "foo,1\r\n",
    "sndse,1,1,10,0\r\n"
  };

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_ascii_command_line_decoder failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    acld_result_t seen;
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen.code      = cmd_code_e'(out_if.cmd_code);
      seen.kind      = reply_kind_e'(out_if.reply_kind);
      seen.ok        = out_if.ok;
      seen.target_id = out_if.target_id;
      seen.arg_a     = out_if.arg_a;
      seen.arg_b     = out_if.arg_b;
      seen.arg_c     = out_if.arg_c;
      line_model.check_reply(seen);
    end
  end

  // receiver side, with the long hold-off counted here
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_out) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_out = 0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  function automatic void put_text(ref byte_q_t q, input string s, input bit mix);
    logic [7:0] c;
    for (int k = 0; k < s.len(); k++) begin
      c = s[k];
      if (mix && $urandom_range(0, 11) == 0)
        q.push_back($urandom_range(0, 1) ? AsciiSpace : AsciiTab);
      if (mix && c >= "a" && c <= "z" && $urandom_range(0, 3) == 0) c = c - CaseOffset;
      q.push_back(c);
    end
  endfunction

  function automatic string arg_text(int pos, bit sound);
    int unsigned pick;
    pick = $urandom_range(0, 13);
    if (pos == 0) begin
      if (pick < 9) return $sformatf("%0d", $urandom_range(0, 3));
      if (pick == 9) return "";
      if (pick == 10) return "-1";
      if (pick == 11) return "+2";
      return $sformatf("%0d", $urandom_range(4, 400));
    end
    if (sound && pick < 10) begin
      case (pos)
        1:       return $sformatf("%0d", $urandom_range(0, 5001));
        2:       return $sformatf("%0d", $urandom_range(9, 20001));
        default: return $sformatf("%0d", $urandom_range(0, 101));
      endcase
    end
    case (pick)
      0: return "";
      1: return $urandom_range(0, 1) ? "+" : "-";
      2: return $sformatf("%0d", int'($urandom_range(0, 23)) - 3);
      3: return $sformatf("+%0d", $urandom_range(0, 999));
      4: return $sformatf("%0d", int'($urandom));
      5: return $sformatf("%s%0d%0d", $urandom_range(0, 1) ? "-" : "", $urandom, $urandom);
      6: begin
        case ($urandom_range(0, 2))
          0:       return "1x";
          1:       return "--2";
          default: return "3+";
        endcase
      end
      7: return $urandom_range(0, 1) ? "-2147483648" : "2147483648";
      default: return $sformatf("%0d", $urandom_range(0, 200));
    endcase
    return "0";
  endfunction

  function automatic void random_line(ref byte_q_t q);
    string       name;
    string       body;
    int unsigned pick;
    int unsigned nf;
    if ($urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(1, 16)) q.push_back(8'($urandom));
      put_text(q, $urandom_range(0, 1) ? "\r\n" : "\n", 0);
      return;
    end
    pick = $urandom_range(0, 19);
    if (pick < 15) begin
      case ($urandom_range(0, 8))
        0:       name = "ledset";
        1:       name = "ledclr";
        2:       name = "ledinv";
        3:       name = "ledget";
        4:       name = "pswget";
        5:       name = "adcget";
        6:       name = "ledfls";
        7:       name = "ledpwm";
        default: name = "sndset";
      endcase
    end else begin
      case (pick)
        15:      name = "ledabc";
        16:      name = "psw";
        17:      name = "adcx";
        18:      name = "hello";
        default: name = "snd";
      endcase
    end
    pick = $urandom_range(0, 19);
    if (pick == 0) nf = 0;
    else if (pick == 1) nf = 5;
    else if (pick == 2) nf = 6;
    else if ((name == "sndset" || name == "ledpwm") && pick < 14) nf = 4;
    else nf = $urandom_range(1, 4);
    body = name;
    for (int f = 0; f < nf; f++) body = {body, ",", arg_text(f, name == "sndset")};
    if ($urandom_range(0, 29) == 0) repeat ($urandom_range(40, 80)) body = {body, "9"};
    put_text(q, body, 1);
    case ($urandom_range(0, 29))
      0:       put_text(q, "\n", 0);
      1:       put_text(q, "\rz\r\n", 0);
      2:       put_text(q, "\r\r\n", 0);
      default: put_text(q, "\r\n", 0);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    line_model.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_line(input byte_q_t q);
    foreach (q[k]) send_byte(q[k]);
  endtask

  initial begin
    byte_q_t     q;
    string       s;
    int unsigned rand_bytes_base;
    int unsigned rand_cmds_base;
    int unsigned line_no;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = 8'h00;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_lines[k]) begin
      q = {};
      put_text(q, directed_lines[k], 0);
      send_line(q);
    end
    // zero byte inside a field, then high-bit noise with no command
    q = {};
    put_text(q, "ledset,0,", 0);
    q.push_back(8'h00);
    put_text(q, "\r\n", 0);
    send_line(q);
    q = {8'hff, 8'h80, 8'h7f, 8'h00, AsciiCr, AsciiLf};
    send_line(q);
    // line length just under and at the limit, then past it
    for (int n = 53; n <= 54; n++) begin
      s = "ledset,0,";
      repeat (n - 1) s = {s, "0"};
      s = {s, "5\r\n"};
      q = {};
      put_text(q, s, 0);
      send_line(q);
    end
    s = "ledget,1,";
    repeat (60) s = {s, "7"};
    q = {};
    put_text(q, {s, "\r\n"}, 0);
    send_line(q);

    rand_bytes_base = bytes_sent;
    rand_cmds_base  = line_model.cmds_expected;
    line_no         = 0;
    while (bytes_sent - rand_bytes_base < 120
           || line_model.cmds_expected - rand_cmds_base < 5) begin
      if (bytes_sent - rand_bytes_base >= 90) idle_on = 0;
      if (line_no == 0) hold_out = 1;
      q = {};
      random_line(q);
      send_line(q);
      line_no++;
    end
    in_if.valid <= 1'b0;

    while (line_model.expected_cmds.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (line_model.fails == 0) begin
      $display("tb_ascii_command_line_decoder passed");
    end else begin
      $display("tb_ascii_command_line_decoder failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/acld_pkg.sv
sv/acld_in_if.sv
sv/acld_out_if.sv
sv/acld_field.sv
sv/acld_check.sv
sv/ascii_command_line_decoder.sv
bench/tb_ascii_command_line_decoder.sv
